// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
// Clock and active-low asynchronous reset are passed in with each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DMTT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("port check failed");

// Next-cycle implication, disabled during reset.
`define DMTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("port check failed");

`endif

// File: sv/dmtt_pkg.sv
// Shared types, constants and index helpers for the transposition table.
// No dependencies; used by every module of the block.
package dmtt_pkg;

	localparam int AI_INDEX_BITS      = 4;
	localparam int FOE_INDEX_BITS     = 4;
	localparam int WEATHER_INDEX_BITS = 2;
	localparam int DEPTH_BITS         = 8;

	localparam int INDEX_BITS  = AI_INDEX_BITS + FOE_INDEX_BITS + WEATHER_INDEX_BITS;
	localparam int TABLE_DEPTH = 1 << INDEX_BITS;
	localparam int KEY_W       = 64;
	localparam int VALUE_W     = 64;
	localparam int SDEPTH_W    = 8;

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

	typedef logic [INDEX_BITS-1:0] index_t;
	typedef logic [DEPTH_BITS-1:0] depth_t;

	typedef enum logic {
		ACT_PROBE = 1'b0,
		ACT_STORE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_LEAF   = 2'd0,
		ST_HIT    = 2'd1,
		ST_MISS   = 2'd2,
		ST_STORED = 2'd3
	} result_code_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_RESOLVE
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]   ai;
		logic [KEY_W-1:0]   foe;
		logic [KEY_W-1:0]   weather;
		logic [VALUE_W-1:0] value;
		depth_t             depth;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;
		logic capture;
		logic commit;
	} dmtt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic out_free;
	} dmtt_sts_t;

	function automatic index_t slot_of(logic [KEY_W-1:0] a, logic [KEY_W-1:0] f,
			logic [KEY_W-1:0] w);
		return {a[AI_INDEX_BITS-1:0], f[FOE_INDEX_BITS-1:0], w[WEATHER_INDEX_BITS-1:0]};
	endfunction

	// clamp the 8-bit request depth into the stored depth width
	function automatic depth_t sat_depth(logic [SDEPTH_W-1:0] d);
		logic [15:0] d_ext;
		d_ext = {8'b0, d};
		if (d_ext > 16'(DEPTH_MAX))
			return DEPTH_MAX;
		else
			return d_ext[DEPTH_BITS-1:0];
	endfunction

endpackage

// File: sv/dmtt_ctrl.sv
// Controller FSM: clearing pass after reset, then capture / resolve per word.
// Depends on dmtt_pkg.
module dmtt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dmtt_pkg::dmtt_sts_t sts,
	output dmtt_pkg::dmtt_cmd_t cmd
);

	dmtt_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= dmtt_pkg::S_CLEAR;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		in_stall    = 1'b1;
		unique case (state_q)
			dmtt_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last)
					state_nxt = dmtt_pkg::S_IDLE;
			end
			dmtt_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = dmtt_pkg::S_RESOLVE;
				end
			end
			dmtt_pkg::S_RESOLVE: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = dmtt_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = dmtt_pkg::S_CLEAR;
			end
		endcase
	end

endmodule

// File: sv/dmtt_datapath.sv
// Datapath: entry memory, clear counter, captured word, compare and output register.
// Depends on dmtt_pkg.
module dmtt_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dmtt_pkg::dmtt_cmd_t                 cmd,
	output dmtt_pkg::dmtt_sts_t                 sts,
	input  logic                                action,
	input  logic [dmtt_pkg::KEY_W-1:0]          ai_key,
	input  logic [dmtt_pkg::KEY_W-1:0]          foe_key,
	input  logic [dmtt_pkg::KEY_W-1:0]          weather_key,
	input  logic [dmtt_pkg::SDEPTH_W-1:0]       search_depth,
	input  logic signed [dmtt_pkg::VALUE_W-1:0] store_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic signed [dmtt_pkg::VALUE_W-1:0] hit_value
);

	dmtt_pkg::entry_t mem [dmtt_pkg::TABLE_DEPTH];

	dmtt_pkg::index_t                 clr_addr_q;
	dmtt_pkg::index_t                 idx_q;
	dmtt_pkg::entry_t                 item_q;
	dmtt_pkg::entry_t                 rd_q;
	logic                             action_q;
	logic                             out_valid_q;
	logic [1:0]                       status_q;
	logic [dmtt_pkg::VALUE_W-1:0]     hit_value_q;

	logic                             wr_en;
	dmtt_pkg::index_t                 wr_addr;
	dmtt_pkg::entry_t                 wr_data;
	logic                             is_store;
	logic                             is_hit;
	logic [1:0]                       res_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_addr_q <= '0;
		else if (cmd.clear)
			clr_addr_q <= clr_addr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q      <= action;
			idx_q         <= dmtt_pkg::slot_of(ai_key, foe_key, weather_key);
			item_q.ai      <= ai_key;
			item_q.foe     <= foe_key;
			item_q.weather <= weather_key;
			item_q.value   <= store_value;
			item_q.depth   <= dmtt_pkg::sat_depth(search_depth);
		end
	end

	// table read, registered
	always_ff @(posedge clk) begin
		if (cmd.capture)
			rd_q <= mem[dmtt_pkg::slot_of(ai_key, foe_key, weather_key)];
	end

	assign is_store = (action_q == dmtt_pkg::ACT_STORE);
	// stored depth of zero never satisfies a probe of depth one or more
	assign is_hit = (rd_q.depth >= item_q.depth) && (rd_q.ai == item_q.ai)
		&& (rd_q.foe == item_q.foe) && (rd_q.weather == item_q.weather);

	always_comb begin
		priority if (is_store)
			res_code = dmtt_pkg::ST_STORED;
		else if (item_q.depth == '0)
			res_code = dmtt_pkg::ST_LEAF;
		else if (is_hit)
			res_code = dmtt_pkg::ST_HIT;
		else
			res_code = dmtt_pkg::ST_MISS;
	end

	always_comb begin
		if (cmd.clear) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en   = cmd.commit && is_store && (item_q.depth != '0);
			wr_addr = idx_q;
			wr_data = item_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.commit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q    <= res_code;
			hit_value_q <= (res_code == dmtt_pkg::ST_HIT) ? rd_q.value : '0;
		end
	end

	assign sts.clr_last = (clr_addr_q == '1);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign hit_value = hit_value_q;

endmodule

// File: sv/direct_mapped_transposition_table_core.sv
// Channel | direction | handshake           | payload
// in      | into core | in_valid / in_stall | action, ai_key, foe_key, weather_key,
//         |           |                     | search_depth, store_value
// out     | from core | out_valid/out_stall | status, hit_value
// Each word is accepted with the table read, then compared and written back in the resolve step.
// Table is one memory port, one access per cycle; a word waits in the resolve step
// while the output register is full and stalled.
// After reset the core clears all 1024 entries, one per cycle, with in_stall high.
// Top level of the direct-mapped transposition table; uses dmtt_pkg, dmtt_ctrl, dmtt_datapath.
module direct_mapped_transposition_table_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic [dmtt_pkg::KEY_W-1:0]          ai_key,
	input  logic [dmtt_pkg::KEY_W-1:0]          foe_key,
	input  logic [dmtt_pkg::KEY_W-1:0]          weather_key,
	input  logic [dmtt_pkg::SDEPTH_W-1:0]       search_depth,
	input  logic signed [dmtt_pkg::VALUE_W-1:0] store_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic signed [dmtt_pkg::VALUE_W-1:0] hit_value
);

	dmtt_pkg::dmtt_cmd_t cmd;
	dmtt_pkg::dmtt_sts_t sts;

	dmtt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dmtt_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.action       (action),
		.ai_key       (ai_key),
		.foe_key      (foe_key),
		.weather_key  (weather_key),
		.search_depth (search_depth),
		.store_value  (store_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.hit_value    (hit_value)
	);

endmodule

// File: sv/dmtt_checker.sv
// Port-level checks on the transposition table core, attached by bind.
// Depends on dmtt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dmtt_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [1:0]                          status,
	input logic signed [dmtt_pkg::VALUE_W-1:0] hit_value
);

	// a stalled result word holds
	`DMTT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(hit_value))

	// only a hit carries a score
	`DMTT_ASSERT_SAME(a_zero_value, clk, arst_n, out_valid && (status != dmtt_pkg::ST_HIT), hit_value == '0)

	// one word in flight: the input stalls straight after an accept
	`DMTT_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && !in_stall, in_stall)

	// a fresh result only follows a cycle in which a word was being resolved
	`DMTT_ASSERT_SAME(a_no_phantom, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind direct_mapped_transposition_table_core dmtt_checker u_dmtt_checker (.*);
